FILE: src/sccs_pkg.sv
// ----------------------------------------------------------------------------
// sccs_pkg
// Shared types and codes for the squared correlation covariance sum core.
// ----------------------------------------------------------------------------
package sccs_pkg;

	// input item kinds, carried in tuser
	typedef enum logic [1:0] {
		MODE_CORR  = 2'd0,
		MODE_PAIR  = 2'd1,
		MODE_SIZE  = 2'd2,
		MODE_START = 2'd3
	} mode_t;

	// configuration register index, paddr[2]
	localparam logic REG_NUM_VARS = 1'b0;
	localparam logic REG_NUM_SETS = 1'b1;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	// request to the shared multiply, round and saturate unit
	typedef struct packed {
		logic               start;
		logic [5:0]         shift;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] result;
	} mul_rsp_t;

endpackage

FILE: src/sccs_ram.sv
// ----------------------------------------------------------------------------
// sccs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sccs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/sccs_mul.sv
// ----------------------------------------------------------------------------
// sccs_mul
// Signed 64x64 multiply over four 32x32 partial products, then shift right
// with rounding half away from zero and saturation to 64 bits.
// ----------------------------------------------------------------------------
module sccs_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  sccs_pkg::mul_req_t req,
	output sccs_pkg::mul_rsp_t rsp
);

	typedef enum logic [1:0] {M_IDLE, M_PP, M_RND, M_OUT} mstate_t;

	mstate_t       state_q;
	logic [2:0]    cnt_q;
	logic          done_q;
	logic          neg_q;
	logic [5:0]    shift_q;
	logic [63:0]   ma_q, mb_q;
	logic [127:0]  prod_q;
	logic [63:0]   pp_s1;
	logic [1:0]    off_s1;
	logic signed [63:0] res_q;

	logic [31:0]   pa, pb;
	logic [127:0]  pp_ext;
	logic [127:0]  q;
	logic [63:0]   lim, qsat;

	assign pa = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign pb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];

	always_comb begin
		case (off_s1)
			2'd0:    pp_ext = {64'd0, pp_s1};
			2'd1:    pp_ext = {32'd0, pp_s1, 32'd0};
			default: pp_ext = {pp_s1, 64'd0};
		endcase
		q    = prod_q >> shift_q;
		lim  = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		qsat = (q[127:64] != 64'd0 || q[63:0] > lim) ? lim : q[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= 3'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						state_q <= M_PP;
						cnt_q   <= 3'd0;
					end
				end
				M_PP: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						state_q <= M_RND;
					end
				end
				M_RND: state_q <= M_OUT;
				M_OUT: begin
					state_q <= M_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				neg_q   <= req.a[63] ^ req.b[63];
				ma_q    <= req.a[63] ? 64'(-req.a) : 64'(req.a);
				mb_q    <= req.b[63] ? 64'(-req.b) : 64'(req.b);
				shift_q <= req.shift;
				prod_q  <= 128'd0;
			end
			M_PP: begin
				pp_s1  <= {32'd0, pa} * {32'd0, pb};
				off_s1 <= 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});
				if (cnt_q != 3'd0) begin
					prod_q <= prod_q + pp_ext;
				end
			end
			M_RND: prod_q <= prod_q + (128'd1 << (shift_q - 6'd1));
			M_OUT: res_q  <= neg_q ? -$signed(qsat) : $signed(qsat);
			default: ;
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

FILE: src/squared_correlation_cov_sum_core.sv
// ----------------------------------------------------------------------------
// squared_correlation_cov_sum_core
// Sum of asymptotic covariances of squared correlations over all ordered
// pairs of variable pairs, one saturating Q24.40 sum per sample-size set.
// ----------------------------------------------------------------------------
//  channel | ports                          | contents
//  s       | s_tvalid s_tready s_tdata/user | loads and start transactions
//  m       | m_tvalid m_tready m_tdata/last | one result per set
//  cfg     | psel penable pwrite paddr ...  | num_vars @0, num_sets @4
//
// Correlation and pair loads are written as they are accepted; a sample-size
// load holds off input while the bit-serial reciprocal divider runs. A start
// clears MAX_SETS accumulators, then walks the quadruples, each product going
// through the one shared multiply unit in turn. Results leave one at a time,
// the next only after the last is taken. Input is taken only while idle.
// Stores hold their contents over reset; accumulators are cleared at start.
// ----------------------------------------------------------------------------
module squared_correlation_cov_sum_core #(
	parameter int MAX_VARS = 32,
	parameter int MAX_SETS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // row[4:0] col[9:5] set_index[13:10] value[45:14]
	                               // sample_size[61:46], zero pad
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // result_set[3:0] sum[67:4], zero pad
	output logic        m_tlast,   // last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NPAIRS = MAX_VARS * (MAX_VARS - 1) / 2;
	localparam int CAW    = $clog2(MAX_VARS * MAX_VARS);
	localparam int PAW    = $clog2(MAX_SETS * NPAIRS);
	localparam int SW     = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
	localparam int SCW    = $clog2(MAX_SETS + 1);
	localparam int IW     = $clog2(MAX_VARS) + 2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_DIVW, ST_CLR, ST_CHECK, ST_ADV, ST_RDC, ST_MISSUE,
		ST_MWAIT, ST_NEG, ST_SRD0, ST_SRD1, ST_SRD2, ST_ORD, ST_OCAP, ST_OWAIT
	} state_t;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? sccs_pkg::S64_MIN : sccs_pkg::S64_MAX;
		end
		return s[63:0];
	endfunction

	function automatic int tri_num(input int b);
		return (b * (b - 1)) >> 1;
	endfunction

	function automatic logic signed [63:0] sx(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	// input fields
	logic [4:0]  in_row, in_col;
	logic [3:0]  in_set;
	logic [31:0] in_value;
	logic [15:0] in_size;
	sccs_pkg::mode_t in_mode;
	logic        s_acc;

	assign in_row   = s_tdata[4:0];
	assign in_col   = s_tdata[9:5];
	assign in_set   = s_tdata[13:10];
	assign in_value = s_tdata[45:14];
	assign in_size  = s_tdata[61:46];
	assign in_mode  = sccs_pkg::mode_t'(s_tuser);

	// control
	state_t     state_q;
	logic [5:0] num_vars_q;
	logic [4:0] num_sets_q;
	logic [SCW-1:0] m_q;
	logic [4:0] step_q;
	logic [2:0] cnt_q;
	logic [4:0] div_cnt_q;
	logic [IW-1:0] i_q, j_q, k_q, l_q;
	logic       out_valid_q;

	// datapath
	logic [31:0] corr_r_q [6];
	logic signed [63:0] sq_q, c_q, t_q, x_q, cn_q, ee_q, acc_q;
	logic [31:0] inv_q, pe_ij_q, pe_kl_q;
	logic [PAW-1:0] pij_q, pkl_q;
	logic [15:0] rem_q, n_q;
	logic [31:0] quo_q;
	logic [SW-1:0] dset_q;
	logic [3:0]  out_set_q;
	logic signed [63:0] out_sum_q;
	logic        out_last_q;

	// derived
	logic [IW-1:0] p;
	logic [SCW-1:0] sets;
	logic [IW-1:0] ni, nj, nk, nl;
	logic        adv_done;
	logic        last_set;
	logic [16:0] trial;
	logic        cfg_wr;

	// memories
	logic            corr_we;
	logic [CAW-1:0]  corr_waddr, corr_raddr;
	logic [31:0]     corr_rdata;
	logic            pair_we;
	logic [PAW-1:0]  pair_waddr, pair_raddr;
	logic [31:0]     pair_rdata;
	logic            inv_we;
	logic [SW-1:0]   inv_raddr;
	logic [31:0]     inv_rdata;
	logic            acc_we;
	logic [63:0]     acc_wdata, acc_rdata;

	sccs_pkg::mul_req_t mul_req;
	sccs_pkg::mul_rsp_t mul_rsp;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			sccs_pkg::REG_NUM_VARS: prdata = {26'd0, num_vars_q};
			default:                prdata = {27'd0, num_sets_q};
		endcase
	end

	assign p = (int'(num_vars_q) > MAX_VARS) ? IW'(MAX_VARS) : IW'(num_vars_q);
	assign sets = (num_sets_q == 5'd0) ? SCW'(1) :
		((int'(num_sets_q) > MAX_SETS) ? SCW'(MAX_SETS) : SCW'(num_sets_q));
	assign last_set = (int'(m_q) + 1 == int'(sets));

	// next quadruple in walk order; an empty inner range shows as l >= p
	always_comb begin
		ni = i_q;
		nj = j_q;
		nk = k_q;
		nl = l_q;
		adv_done = 1'b0;
		if (l_q + IW'(1) < p) begin
			nl = l_q + IW'(1);
		end else if (k_q + IW'(2) < p) begin
			nk = k_q + IW'(1);
			nl = k_q + IW'(2);
		end else if (j_q + IW'(1) < p) begin
			nj = j_q + IW'(1);
			nk = i_q;
			nl = j_q + IW'(2);
		end else if (i_q + IW'(2) < p) begin
			ni = i_q + IW'(1);
			nj = i_q + IW'(2);
			nk = i_q + IW'(1);
			nl = i_q + IW'(3);
		end else begin
			adv_done = 1'b1;
		end
	end

	// loads
	assign corr_we = s_acc && in_mode == sccs_pkg::MODE_CORR &&
		int'(in_row) < MAX_VARS && int'(in_col) < MAX_VARS;
	assign corr_waddr = CAW'(int'(in_row) * MAX_VARS + int'(in_col));
	assign pair_we = s_acc && in_mode == sccs_pkg::MODE_PAIR &&
		int'(in_row) < MAX_VARS && int'(in_col) < MAX_VARS &&
		int'(in_set) < MAX_SETS && in_row != in_col;
	assign pair_waddr = (in_row < in_col) ?
		PAW'(int'(in_set) * NPAIRS + tri_num(int'(in_col)) + int'(in_row)) :
		PAW'(int'(in_set) * NPAIRS + tri_num(int'(in_row)) + int'(in_col));
	assign inv_we = (state_q == ST_DIVW);
	assign inv_raddr = m_q[SW-1:0];
	assign pair_raddr = PAW'(int'(m_q) * NPAIRS +
		int'(state_q == ST_SRD1 ? pkl_q : pij_q));

	always_comb begin
		case (cnt_q)
			3'd1:    corr_raddr = CAW'(int'(k_q) * MAX_VARS + int'(l_q));
			3'd2:    corr_raddr = CAW'(int'(i_q) * MAX_VARS + int'(k_q));
			3'd3:    corr_raddr = CAW'(int'(j_q) * MAX_VARS + int'(l_q));
			3'd4:    corr_raddr = CAW'(int'(i_q) * MAX_VARS + int'(l_q));
			3'd5:    corr_raddr = CAW'(int'(j_q) * MAX_VARS + int'(k_q));
			default: corr_raddr = CAW'(int'(i_q) * MAX_VARS + int'(j_q));
		endcase
	end

	// corr_r_q: 0 rij, 1 rkl, 2 rik, 3 rjl, 4 ril, 5 rjk
	always_comb begin
		mul_req.start = (state_q == ST_MISSUE);
		mul_req.shift = 6'd20;
		mul_req.a     = sx(corr_r_q[2]);
		mul_req.b     = sx(corr_r_q[2]);
		case (step_q)
			5'd0: ;
			5'd1: begin mul_req.a = sx(corr_r_q[4]); mul_req.b = sx(corr_r_q[4]); end
			5'd2: begin mul_req.a = sx(corr_r_q[5]); mul_req.b = sx(corr_r_q[5]); end
			5'd3: begin mul_req.a = sx(corr_r_q[3]); mul_req.b = sx(corr_r_q[3]); end
			5'd4: begin mul_req.a = sx(corr_r_q[0]); mul_req.b = sx(corr_r_q[1]); end
			5'd5: begin mul_req.a = x_q; mul_req.b = sq_q; mul_req.shift = 6'd41; end
			5'd6: begin mul_req.a = sx(corr_r_q[2]); mul_req.b = sx(corr_r_q[3]); end
			5'd7: begin mul_req.a = sx(corr_r_q[4]); mul_req.b = sx(corr_r_q[5]); end
			5'd8: begin mul_req.a = sx(corr_r_q[0]); mul_req.b = sx(corr_r_q[2]); end
			5'd9: begin mul_req.a = x_q; mul_req.b = sx(corr_r_q[4]); mul_req.shift = 6'd30; end
			5'd10: begin mul_req.a = sx(corr_r_q[0]); mul_req.b = sx(corr_r_q[5]); end
			5'd11: begin mul_req.a = x_q; mul_req.b = sx(corr_r_q[3]); mul_req.shift = 6'd30; end
			5'd12: begin mul_req.a = sx(corr_r_q[2]); mul_req.b = sx(corr_r_q[5]); end
			5'd13: begin mul_req.a = x_q; mul_req.b = sx(corr_r_q[1]); mul_req.shift = 6'd30; end
			5'd14: begin mul_req.a = sx(corr_r_q[4]); mul_req.b = sx(corr_r_q[3]); end
			5'd15: begin mul_req.a = x_q; mul_req.b = sx(corr_r_q[1]); mul_req.shift = 6'd30; end
			5'd16: begin mul_req.a = c_q; mul_req.b = {32'd0, inv_q}; mul_req.shift = 6'd31; end
			5'd17: begin mul_req.a = sx(pe_ij_q); mul_req.b = sx(pe_kl_q); mul_req.shift = 6'd19; end
			5'd18: begin mul_req.a = sat_add(ee_q, cn_q); mul_req.b = cn_q; mul_req.shift = 6'd40; end
			default: ;
		endcase
	end

	assign acc_we = (state_q == ST_CLR) ||
		(state_q == ST_MWAIT && mul_rsp.done && step_q == 5'd18);
	assign acc_wdata = (state_q == ST_CLR) ? 64'd0 : sat_add(acc_q, mul_rsp.result);

	assign trial = {rem_q, (div_cnt_q == 5'd0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			num_vars_q  <= 6'd2;
			num_sets_q  <= 5'd1;
			m_q         <= '0;
			step_q      <= 5'd0;
			cnt_q       <= 3'd0;
			div_cnt_q   <= 5'd0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			l_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					sccs_pkg::REG_NUM_VARS: num_vars_q <= pwdata[5:0];
					default:                num_sets_q <= pwdata[4:0];
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc && in_mode == sccs_pkg::MODE_SIZE &&
						int'(in_set) < MAX_SETS) begin
						state_q   <= ST_DIV;
						div_cnt_q <= 5'd0;
					end else if (s_acc && in_mode == sccs_pkg::MODE_START) begin
						state_q <= ST_CLR;
						m_q     <= '0;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd31) begin
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: state_q <= ST_IDLE;
				ST_CLR: begin
					m_q <= m_q + SCW'(1);
					if (int'(m_q) == MAX_SETS - 1) begin
						state_q <= ST_CHECK;
						i_q     <= IW'(0);
						j_q     <= IW'(1);
						k_q     <= IW'(0);
						l_q     <= IW'(2);
					end
				end
				ST_CHECK: begin
					cnt_q   <= 3'd0;
					state_q <= (l_q < p) ? ST_RDC : ST_ADV;
				end
				ST_ADV: begin
					if (adv_done) begin
						state_q <= ST_ORD;
						m_q     <= '0;
					end else begin
						i_q     <= ni;
						j_q     <= nj;
						k_q     <= nk;
						l_q     <= nl;
						state_q <= ST_CHECK;
					end
				end
				ST_RDC: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd6) begin
						state_q <= ST_MISSUE;
						step_q  <= 5'd0;
					end
				end
				ST_MISSUE: state_q <= ST_MWAIT;
				ST_MWAIT: begin
					if (mul_rsp.done) begin
						if (step_q == 5'd15) begin
							state_q <= ST_NEG;
						end else if (step_q == 5'd18) begin
							m_q     <= m_q + SCW'(1);
							state_q <= last_set ? ST_ADV : ST_SRD0;
						end else begin
							step_q  <= step_q + 5'd1;
							state_q <= ST_MISSUE;
						end
					end
				end
				ST_NEG: begin
					m_q     <= '0;
					state_q <= ST_SRD0;
				end
				ST_SRD0: state_q <= ST_SRD1;
				ST_SRD1: state_q <= ST_SRD2;
				ST_SRD2: begin
					step_q  <= 5'd16;
					state_q <= ST_MISSUE;
				end
				ST_ORD: state_q <= ST_OCAP;
				ST_OCAP: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_OWAIT;
				end
				ST_OWAIT: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							m_q     <= m_q + SCW'(1);
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		logic signed [63:0] dbl;
		dbl = sat_add(acc_rdata, acc_rdata);
		case (state_q)
			ST_IDLE: begin
				rem_q  <= 16'd0;
				quo_q  <= 32'd0;
				n_q    <= (in_size == 16'd0) ? 16'd1 : in_size;
				dset_q <= SW'(in_set);
			end
			ST_DIV: begin
				if (trial >= {1'b0, n_q}) begin
					rem_q <= 16'(trial - {1'b0, n_q});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= trial[15:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			ST_CHECK: begin
				pij_q <= PAW'(tri_num(int'(j_q)) + int'(i_q));
				pkl_q <= PAW'(tri_num(int'(l_q)) + int'(k_q));
			end
			ST_RDC: begin
				if (cnt_q != 3'd0) begin
					corr_r_q[cnt_q - 3'd1] <= corr_rdata;
				end
			end
			ST_MWAIT: begin
				if (mul_rsp.done) begin
					case (step_q)
						5'd0: sq_q <= mul_rsp.result;
						5'd1, 5'd2, 5'd3: sq_q <= sat_add(sq_q, mul_rsp.result);
						5'd5: c_q <= mul_rsp.result;
						5'd6, 5'd7: c_q <= sat_add(c_q, mul_rsp.result);
						5'd9: t_q <= mul_rsp.result;
						5'd11, 5'd13, 5'd15: t_q <= sat_add(t_q, mul_rsp.result);
						5'd16: cn_q <= mul_rsp.result;
						5'd17: ee_q <= mul_rsp.result;
						5'd18: ;
						default: x_q <= mul_rsp.result;
					endcase
				end
			end
			ST_NEG: c_q <= sat_add(c_q, (t_q == sccs_pkg::S64_MIN) ?
				sccs_pkg::S64_MAX : -t_q);
			ST_SRD1: begin
				inv_q   <= inv_rdata;
				pe_ij_q <= pair_rdata;
				acc_q   <= acc_rdata;
			end
			ST_SRD2: pe_kl_q <= pair_rdata;
			ST_OCAP: begin
				out_set_q  <= 4'(m_q);
				out_sum_q  <= sat_add(dbl, dbl);
				out_last_q <= last_set;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_sum_q, out_set_q};
	assign m_tlast  = out_last_q;

	sccs_ram #(.WIDTH(32), .DEPTH(MAX_VARS * MAX_VARS)) u_corr_ram (
		.clk(clk), .we(corr_we), .waddr(corr_waddr), .wdata(in_value),
		.raddr(corr_raddr), .rdata(corr_rdata)
	);

	sccs_ram #(.WIDTH(32), .DEPTH(MAX_SETS * NPAIRS)) u_pair_ram (
		.clk(clk), .we(pair_we), .waddr(pair_waddr), .wdata(in_value),
		.raddr(pair_raddr), .rdata(pair_rdata)
	);

	sccs_ram #(.WIDTH(32), .DEPTH(MAX_SETS)) u_inv_ram (
		.clk(clk), .we(inv_we), .waddr(dset_q), .wdata(quo_q),
		.raddr(inv_raddr), .rdata(inv_rdata)
	);

	sccs_ram #(.WIDTH(64), .DEPTH(MAX_SETS)) u_acc_ram (
		.clk(clk), .we(acc_we), .waddr(m_q[SW-1:0]), .wdata(acc_wdata),
		.raddr(m_q[SW-1:0]), .rdata(acc_rdata)
	);

	sccs_mul u_mul (
		.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp)
	);

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while result pending");

	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> state_q == ST_MWAIT) else $error("unexpected product");

	a_issue_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MISSUE |=> state_q == ST_MWAIT) else $error("issue slip");

	a_next_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> !m_tvalid)
		else $error("result repeated");

endmodule
